// File: rtl/s5ch_pkg.sv
`timescale 1ns / 1ps

package s5ch_pkg;

  // Most result items that one input item can cause: the request header,
  // with an empty host name, followed by both port bytes.
  localparam int unsigned MaxResults = 7;
  localparam int unsigned ResCntW    = $clog2(MaxResults + 1);

  // Input commands.
  localparam logic [1:0] CmdStart = 2'd0;
  localparam logic [1:0] CmdHost  = 2'd1;
  localparam logic [1:0] CmdRecv  = 2'd2;
  localparam logic [1:0] CmdClose = 2'd3;

  // Result kinds.
  localparam logic KindByte   = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Status codes.
  localparam logic [2:0] StConnected = 3'd0;
  localparam logic [2:0] StInvalid   = 3'd1;
  localparam logic [2:0] StFailed    = 3'd2;
  localparam logic [2:0] StClosed    = 3'd3;
  localparam logic [2:0] StBadSeq    = 3'd4;

  // Configuration register indexes.
  localparam logic CfgDestPort   = 1'b0;
  localparam logic CfgHostLength = 1'b1;

  // Protocol bytes.
  localparam logic [7:0] SocksVersion = 8'h05;
  localparam logic [7:0] CmdConnect   = 8'h01;
  localparam logic [7:0] MethodNoAuth = 8'h00;
  localparam logic [7:0] ByteZero     = 8'h00;
  localparam logic [7:0] AtypIpv4     = 8'h01;
  localparam logic [7:0] AtypDomain   = 8'h03;
  localparam logic [7:0] AtypIpv6     = 8'h04;

  // Reply lengths: header of five bytes, address remainder, two port bytes.
  localparam logic [8:0] ReplyHeadLen   = 9'd5;
  localparam logic [8:0] ReplyDomainAdd = 9'd7;
  localparam logic [8:0] ReplyIpv4Len   = 9'd10;
  localparam logic [8:0] ReplyIpv6Len   = 9'd22;

  typedef enum logic [4:0] {
    PhIdle  = 5'b00001,
    PhGreet = 5'b00010,
    PhHost  = 5'b00100,
    PhReply = 5'b01000,
    PhConn  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic [2:0] status;
  } res_entry_t;

  function automatic res_entry_t mk_byte(logic [7:0] b);
    res_entry_t e;
    e.kind    = KindByte;
    e.tx_byte = b;
    e.status  = StConnected;
    return e;
  endfunction

  function automatic res_entry_t mk_status(logic [2:0] s);
    res_entry_t e;
    e.kind    = KindStatus;
    e.tx_byte = 8'h00;
    e.status  = s;
    return e;
  endfunction

endpackage

// File: rtl/socks5_client_handshake.sv
`timescale 1ns / 1ps

// Client side of a SOCKS5 CONNECT handshake without authentication.
// Input channel (in_valid_i / in_stall_o): one command per transfer, a start,
// a host-name byte, a byte received from the proxy, or transport closed.
// Output channel (out_valid_o / out_stall_i): bytes to transmit and status
// reports, one per transfer; out_last_o marks the final result of a command.
// Configuration: cfg_we_i writes dest_port (index 0) or host_length (index 1);
// the user must write only while the block is idle, the block does not enforce it.
// The first result of a command is presented in the cycle after the command's
// transfer. A command is processed in its accept cycle and all its results are
// loaded at once into a seven-entry shift buffer, which drains one result per
// cycle while the receiver does not stall. A command with zero results, or with
// one while the receiver does not stall, can follow every cycle; a command
// with more results holds off the input while the single output port drains it.
// When the receiver stalls, the head result holds and the input stalls while
// any result is still to deliver.
// Reset clears the handshake state to idle, empties the buffer and zeroes
// both configuration registers.
module socks5_client_handshake (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] in_cmd_i,
  input  logic [7:0] in_data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_kind_o,
  output logic [7:0] out_tx_byte_o,
  output logic [2:0] out_status_o,
  output logic       out_last_o
);
  import s5ch_pkg::*;

  logic [15:0] dest_port_q;
  logic [7:0]  host_length_q;

  phase_e     phase_q, phase_d;
  logic [8:0] byte_count_q, byte_count_d;
  logic [8:0] reply_total_q, reply_total_d;
  logic [1:0] err_flags_q, err_flags_d;
  logic [7:0] addr_type_q, addr_type_d;

  res_entry_t           res_buf_q [MaxResults];
  res_entry_t           res_new   [MaxResults];
  logic [ResCntW-1:0]   res_cnt_q;
  logic [ResCntW-1:0]   res_new_cnt;

  logic in_xfer;
  logic out_xfer;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_port_q   <= '0;
      host_length_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDestPort:   dest_port_q   <= cfg_data_i;
        CfgHostLength: host_length_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshake state and the results of the offered command.
  always_comb begin
    logic [8:0] cnt_inc;
    logic [1:0] flags_greet;
    cnt_inc     = byte_count_q + 9'd1;
    flags_greet = '0;

    phase_d       = phase_q;
    byte_count_d  = byte_count_q;
    reply_total_d = reply_total_q;
    err_flags_d   = err_flags_q;
    addr_type_d   = addr_type_q;
    res_new       = '{default: '0};
    res_new_cnt   = '0;

    case (in_cmd_i)
      CmdStart: begin
        if (phase_q == PhIdle) begin
          res_new[0]   = mk_byte(SocksVersion);
          res_new[1]   = mk_byte(CmdConnect);
          res_new[2]   = mk_byte(MethodNoAuth);
          res_new_cnt  = ResCntW'(3);
          phase_d      = PhGreet;
          byte_count_d = '0;
          err_flags_d  = '0;
        end else if (phase_q == PhConn) begin
          res_new[0]  = mk_status(StConnected);
          res_new_cnt = ResCntW'(1);
        end else begin
          res_new[0]  = mk_status(StBadSeq);
          res_new_cnt = ResCntW'(1);
        end
      end

      CmdHost: begin
        if (phase_q == PhHost) begin
          res_new[0]   = mk_byte(in_data_byte_i);
          res_new_cnt  = ResCntW'(1);
          byte_count_d = cnt_inc;
          if (cnt_inc >= {1'b0, host_length_q}) begin
            // Host name complete: the port follows, then the reply is parsed.
            res_new[1]    = mk_byte(dest_port_q[15:8]);
            res_new[2]    = mk_byte(dest_port_q[7:0]);
            res_new_cnt   = ResCntW'(3);
            phase_d       = PhReply;
            byte_count_d  = '0;
            reply_total_d = ReplyHeadLen;
            err_flags_d   = '0;
            addr_type_d   = '0;
          end
        end else begin
          res_new[0]  = mk_status(StBadSeq);
          res_new_cnt = ResCntW'(1);
        end
      end

      CmdRecv: begin
        if (phase_q == PhGreet) begin
          if (byte_count_q == '0) begin
            err_flags_d[0] = err_flags_q[0] | (in_data_byte_i != SocksVersion);
            byte_count_d   = 9'd1;
          end else begin
            flags_greet    = err_flags_q;
            flags_greet[0] = flags_greet[0] | (in_data_byte_i != MethodNoAuth);
            if (flags_greet != '0) begin
              res_new[0]   = mk_status(StInvalid);
              res_new_cnt  = ResCntW'(1);
              phase_d      = PhIdle;
              byte_count_d = '0;
              err_flags_d  = '0;
            end else begin
              // Greeting accepted: send the request header.
              res_new[0]   = mk_byte(SocksVersion);
              res_new[1]   = mk_byte(CmdConnect);
              res_new[2]   = mk_byte(ByteZero);
              res_new[3]   = mk_byte(AtypDomain);
              res_new[4]   = mk_byte(host_length_q);
              res_new_cnt  = ResCntW'(5);
              phase_d      = PhHost;
              byte_count_d = '0;
              err_flags_d  = flags_greet;
              if (host_length_q == '0) begin
                res_new[5]    = mk_byte(dest_port_q[15:8]);
                res_new[6]    = mk_byte(dest_port_q[7:0]);
                res_new_cnt   = ResCntW'(7);
                phase_d       = PhReply;
                reply_total_d = ReplyHeadLen;
                err_flags_d   = '0;
                addr_type_d   = '0;
              end
            end
          end
        end else if (phase_q == PhReply) begin
          if (byte_count_q < 9'd4) begin
            // Reply header: version, reply code, reserved, address type.
            case (byte_count_q[1:0])
              2'd0: err_flags_d[0] = err_flags_q[0] | (in_data_byte_i != SocksVersion);
              2'd1: err_flags_d[1] = err_flags_q[1] | (in_data_byte_i != ByteZero);
              2'd2: err_flags_d[0] = err_flags_q[0] | (in_data_byte_i != ByteZero);
              default: addr_type_d = in_data_byte_i;
            endcase
            byte_count_d = cnt_inc;
          end else if (byte_count_q == 9'd4) begin
            byte_count_d = ReplyHeadLen;
            if (err_flags_q[0]) begin
              res_new[0]  = mk_status(StInvalid);
              res_new_cnt = ResCntW'(1);
            end else if (err_flags_q[1]) begin
              res_new[0]  = mk_status(StFailed);
              res_new_cnt = ResCntW'(1);
            end else if (addr_type_q == AtypDomain) begin
              reply_total_d = ReplyDomainAdd + {1'b0, in_data_byte_i};
            end else if (addr_type_q == AtypIpv4) begin
              reply_total_d = ReplyIpv4Len;
            end else if (addr_type_q == AtypIpv6) begin
              reply_total_d = ReplyIpv6Len;
            end else begin
              res_new[0]  = mk_status(StInvalid);
              res_new_cnt = ResCntW'(1);
            end
            if (res_new_cnt != '0) begin
              phase_d      = PhIdle;
              byte_count_d = '0;
              err_flags_d  = '0;
            end
          end else begin
            // Address and port bytes are discarded.
            byte_count_d = cnt_inc;
            if (cnt_inc >= reply_total_q) begin
              res_new[0]   = mk_status(StConnected);
              res_new_cnt  = ResCntW'(1);
              phase_d      = PhConn;
              byte_count_d = '0;
            end
          end
        end else begin
          res_new[0]  = mk_status(StBadSeq);
          res_new_cnt = ResCntW'(1);
        end
      end

      CmdClose: begin
        res_new_cnt = ResCntW'(1);
        if (phase_q == PhIdle) begin
          res_new[0] = mk_status(StBadSeq);
        end else begin
          res_new[0]   = mk_status(StClosed);
          phase_d      = PhIdle;
          byte_count_d = '0;
          err_flags_d  = '0;
        end
      end

      default: ;
    endcase
  end

  // A new command is taken once at most the head result is left and it leaves now.
  assign out_valid_o = (res_cnt_q != '0);
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign in_stall_o  = !((res_cnt_q == '0) || ((res_cnt_q == ResCntW'(1)) && !out_stall_i));
  assign in_xfer     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhIdle;
      byte_count_q  <= '0;
      reply_total_q <= ReplyHeadLen;
      err_flags_q   <= '0;
      addr_type_q   <= '0;
    end else if (in_xfer) begin
      phase_q       <= phase_d;
      byte_count_q  <= byte_count_d;
      reply_total_q <= reply_total_d;
      err_flags_q   <= err_flags_d;
      addr_type_q   <= addr_type_d;
    end
  end

  // Result buffer count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= '0;
    end else if (in_xfer) begin
      res_cnt_q <= res_new_cnt;
    end else if (out_xfer) begin
      res_cnt_q <= res_cnt_q - ResCntW'(1);
    end
  end

  // Result buffer payload: loaded whole, shifted toward the head on each output transfer.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_buf_q <= res_new;
    end else if (out_xfer) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        res_buf_q[i] <= res_buf_q[i+1];
      end
    end
  end

  assign out_kind_o    = res_buf_q[0].kind;
  assign out_tx_byte_o = res_buf_q[0].tx_byte;
  assign out_status_o  = res_buf_q[0].status;
  assign out_last_o    = (res_cnt_q == ResCntW'(1));

  // The buffer never holds more results than one command can cause.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= ResCntW'(MaxResults))
    else $error("result buffer count out of range");

  // A command is only taken when no undelivered result would be overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> (res_cnt_q == '0) || ((res_cnt_q == ResCntW'(1)) && out_xfer))
    else $error("command accepted over pending results");

  // Idle always starts from a clean count and clean error flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) |-> (byte_count_q == '0) && (err_flags_q == '0))
    else $error("idle with stale handshake state");

  // The greeting reply is two bytes long.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhGreet) |-> (byte_count_q <= 9'd1))
    else $error("greeting reply count overrun");

  // Past the header the reply count stays below the expected length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhReply) && (byte_count_q >= ReplyHeadLen) |-> byte_count_q < reply_total_q)
    else $error("reply count passed its total");

endmodule
